FILE: rtl/core/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants of the binomial probability unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpu_pkg;

  localparam int unsigned MAX_TRIALS_DEF     = 34;
  localparam int unsigned PROB_FRAC_BITS_DEF = 16;

  localparam int unsigned CNT_FIELD_W  = 6;
  localparam int unsigned PROB_FIELD_W = 17;
  localparam int unsigned RES_W        = 32;

  typedef struct packed {
    logic [CNT_FIELD_W-1:0]  trials;
    logic [CNT_FIELD_W-1:0]  successes;
    logic [PROB_FIELD_W-1:0] success_prob;
    logic                    cumulative;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] probability;
    logic             status;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PAS_STEP,
    OP_ROT,
    OP_TERM,
    OP_MUL_P,
    OP_MUL_Q,
    OP_ITER_CLR,
    OP_ADD,
    OP_NEXT,
    OP_ACC,
    OP_SHIFT,
    OP_ROUND,
    OP_PUSH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic pas_done;
    logic cnt_at_x;
    logic limb_last;
    logic expp_done;
    logic expq_done;
    logic x_last;
    logic shift_done;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/binomial_probability_unit_core.sv
// ----------------------------------------------------------------------------
// binomial_probability_unit_core
// Exact binomial PMF or CDF in fixed point, Q1.16 in and Q0.32 out.
// ----------------------------------------------------------------------------
// One query at a time. With M = MAX_TRIALS, L = ceil((M*PROB_FRAC_BITS+1)/32)
// limbs of 32 bits and n trials, a query builds the Pascal row on the
// coefficient shift line, rotates to the first coefficient s (0 for the
// CDF, successes for the PMF), then for each summed term multiplies by p
// and q and adds on the 32-bit limb-serial multiply-add unit, then scales
// and rounds. A query with successes above trials skips the computation
// and returns status set with a zero probability. A finished result sits
// in the output register while the next query is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binomial_probability_unit_core
  import bpu_pkg::*;
#(
  parameter int unsigned MAX_TRIALS     = MAX_TRIALS_DEF,
  parameter int unsigned PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_stall_o,
  input  wire in_t in_data_i,
  output logic     out_valid_o,
  input  wire      out_stall_i,
  output out_t     out_data_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  bpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .busy_o      (busy),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bpu_dpath #(
    .MAX_TRIALS     (MAX_TRIALS),
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  assign in_stall_o = busy;

  a_busy_after_transfer : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o
  ) else $error("input transfer did not start a query");

  a_bad_gives_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.probability == '0
  ) else $error("error status with nonzero probability");

  a_push_only_when_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_PUSH |-> in_stall_o
  ) else $error("result pushed while idle");

endmodule

`default_nettype wire

FILE: rtl/core/bpu_dpath.sv
// ----------------------------------------------------------------------------
// bpu_dpath
// Pascal row line, limb-serial multiplier and adder, sum, scaler and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpu_dpath
  import bpu_pkg::*;
#(
  parameter int unsigned MAX_TRIALS     = MAX_TRIALS_DEF,
  parameter int unsigned PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire in_t   in_data_i,
  output stat_t      stat_o,
  output out_t       out_data_o
);

  localparam int unsigned F     = PROB_FRAC_BITS;
  localparam int unsigned D     = MAX_TRIALS + 1;
  localparam int unsigned CFW   = MAX_TRIALS;
  localparam int unsigned PW    = F + 1;
  localparam int unsigned MW    = (PW > PROB_FIELD_W) ? PW : PROB_FIELD_W;
  localparam int unsigned NL    = (MAX_TRIALS * F + 1 + 31) / 32;
  localparam int unsigned TW    = NL * 32;
  localparam int unsigned AW    = TW + 72;
  localparam int unsigned CNTW  = $clog2(D + NL + 1);
  localparam int unsigned PRW   = 32 + PW + 1;
  localparam int unsigned CRW   = PW + 1;
  localparam int unsigned RW    = F + 41;

  localparam logic [PW-1:0] ONE = PW'(1) << F;

  logic [CFW-1:0]         line_q [D];
  logic [CFW-1:0]         line_d [D];
  logic [CFW-1:0]         prev_q, prev_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic [CNT_FIELD_W-1:0] iter_q, iter_d;
  logic [CNT_FIELD_W-1:0] n_q, n_d, k_q, k_d, x_q, x_d;
  logic [PW-1:0]          p_q, p_d;
  logic                   bad_q, bad_d;
  logic [TW-1:0]          term_q, term_d, sum_q, sum_d;
  logic [CRW-1:0]         carry_q, carry_d;
  logic [AW-1:0]          acc_q, acc_d;
  logic [RES_W-1:0]       res_q, res_d;
  logic                   sts_q, sts_d;
  out_t                   out_q, out_d;

  logic [CNT_FIELD_W-1:0] n_in;
  logic [MW-1:0]          p_ext;
  logic [PW-1:0]          q_val, mul_m;
  logic [PRW-1:0]         prod;
  logic [32:0]            add_s;
  logic                   pas_last, limb_last;
  logic [RW-1:0]          rnd;
  logic                   sat;

  assign pas_last  = (cnt_q == CNTW'(D - 1));
  assign limb_last = (cnt_q == CNTW'(NL - 1));
  assign q_val     = ONE - p_q;
  assign mul_m     = (cmd_i.op == OP_MUL_P) ? p_q : q_val;
  assign prod      = PRW'(term_q[31:0]) * PRW'(mul_m) + PRW'(carry_q);
  assign add_s     = 33'(sum_q[31:0]) + 33'(term_q[31:0]) + 33'(carry_q[0]);
  assign rnd       = RW'(acc_q[F+39:0]) + (RW'(1) << (F - 1));

  assign n_in  = (in_data_i.trials > CNT_FIELD_W'(MAX_TRIALS)) ?
                 CNT_FIELD_W'(MAX_TRIALS) : in_data_i.trials;
  assign p_ext = MW'(in_data_i.success_prob);

  always_comb begin
    if (n_q == '0) begin
      sat = |acc_q[AW-1:32];
    end else begin
      sat = (|acc_q[AW-1:F+40]) || (|rnd[RW-1:F+32]);
    end
  end

  always_comb begin
    line_d  = line_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    iter_d  = iter_q;
    n_d     = n_q;
    k_d     = k_q;
    x_d     = x_q;
    p_d     = p_q;
    bad_d   = bad_q;
    term_d  = term_q;
    sum_d   = sum_q;
    carry_d = carry_q;
    acc_d   = acc_q;
    res_d   = res_q;
    sts_d   = sts_q;
    out_d   = out_q;
    case (cmd_i.op)
      OP_LOAD: begin
        n_d   = n_in;
        k_d   = in_data_i.successes;
        p_d   = (p_ext > MW'(ONE)) ? ONE : PW'(p_ext);
        bad_d = in_data_i.successes > n_in;
        x_d   = in_data_i.cumulative ? '0 : in_data_i.successes;
        for (int i = 0; i < D; i++) begin
          line_d[i] = '0;
        end
        line_d[0] = CFW'(1);
        prev_d = '0;
        cnt_d  = '0;
        iter_d = '0;
        sum_d  = '0;
        res_d  = '0;
        sts_d  = in_data_i.successes > n_in;
      end
      OP_PAS_STEP: begin
        for (int i = 0; i < D - 1; i++) begin
          line_d[i] = line_q[i+1];
        end
        line_d[D-1] = line_q[0] + prev_q;
        if (pas_last) begin
          prev_d = '0;
          cnt_d  = '0;
          iter_d = iter_q + 1'b1;
        end else begin
          prev_d = line_q[0];
          cnt_d  = cnt_q + 1'b1;
        end
      end
      OP_ROT, OP_NEXT: begin
        for (int i = 0; i < D - 1; i++) begin
          line_d[i] = line_q[i+1];
        end
        line_d[D-1] = line_q[0];
        if (cmd_i.op == OP_ROT) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      OP_TERM: begin
        term_d  = TW'(line_q[0]);
        iter_d  = '0;
        cnt_d   = '0;
        carry_d = '0;
      end
      OP_MUL_P, OP_MUL_Q: begin
        term_d = (term_q >> 32) | (TW'(prod[31:0]) << (TW - 32));
        if (limb_last) begin
          cnt_d   = '0;
          carry_d = '0;
          iter_d  = iter_q + 1'b1;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          carry_d = CRW'(prod >> 32);
        end
      end
      OP_ITER_CLR: begin
        iter_d = '0;
      end
      OP_ADD: begin
        sum_d  = (sum_q >> 32) | (TW'(add_s[31:0]) << (TW - 32));
        term_d = term_q >> 32;
        if (limb_last) begin
          cnt_d   = '0;
          carry_d = '0;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          carry_d = CRW'(add_s[32]);
        end
      end
      OP_ACC: begin
        acc_d  = AW'(sum_q) << 32;
        iter_d = '0;
      end
      OP_SHIFT: begin
        acc_d  = acc_q >> F;
        iter_d = iter_q + 1'b1;
      end
      OP_ROUND: begin
        sts_d = 1'b0;
        if (sat) begin
          res_d = '1;
        end else if (n_q == '0) begin
          res_d = acc_q[31:0];
        end else begin
          res_d = rnd[F+31:F];
        end
      end
      OP_PUSH: begin
        out_d.probability = res_q;
        out_d.status      = sts_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      iter_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q  <= line_d;
    prev_q  <= prev_d;
    n_q     <= n_d;
    k_q     <= k_d;
    x_q     <= x_d;
    p_q     <= p_d;
    bad_q   <= bad_d;
    term_q  <= term_d;
    sum_q   <= sum_d;
    carry_q <= carry_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    sts_q   <= sts_d;
    out_q   <= out_d;
  end

  assign stat_o.bad        = bad_q;
  assign stat_o.pas_done   = (iter_q == n_q);
  assign stat_o.cnt_at_x   = (cnt_q == CNTW'(x_q));
  assign stat_o.limb_last  = limb_last;
  assign stat_o.expp_done  = (iter_q == x_q);
  assign stat_o.expq_done  = (iter_q == (n_q - x_q));
  assign stat_o.x_last     = (x_q == k_q);
  assign stat_o.shift_done = (n_q == '0) || (iter_q == (n_q - 1'b1));
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/bpu_ctrl.sv
// ----------------------------------------------------------------------------
// bpu_ctrl
// Sequencer of the binomial probability unit and output valid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpu_ctrl
  import bpu_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       busy_o,
  input  wire        out_stall_i,
  output logic       out_valid_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_CHK   = 12'b0000_0000_0010,
    S_PAS   = 12'b0000_0000_0100,
    S_SEEK  = 12'b0000_0000_1000,
    S_TERM  = 12'b0000_0001_0000,
    S_MULP  = 12'b0000_0010_0000,
    S_MULQ  = 12'b0000_0100_0000,
    S_ADD   = 12'b0000_1000_0000,
    S_NEXT  = 12'b0001_0000_0000,
    S_SHIFT = 12'b0010_0000_0000,
    S_ROUND = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   push;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    push      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        state_d = stat_i.bad ? S_FIN : S_PAS;
      end
      S_PAS: begin
        if (stat_i.pas_done) begin
          state_d = S_SEEK;
        end else begin
          cmd_o.op = OP_PAS_STEP;
        end
      end
      S_SEEK: begin
        if (stat_i.cnt_at_x) begin
          state_d = S_TERM;
        end else begin
          cmd_o.op = OP_ROT;
        end
      end
      S_TERM: begin
        cmd_o.op = OP_TERM;
        state_d  = S_MULP;
      end
      S_MULP: begin
        if (stat_i.expp_done) begin
          cmd_o.op = OP_ITER_CLR;
          state_d  = S_MULQ;
        end else begin
          cmd_o.op = OP_MUL_P;
        end
      end
      S_MULQ: begin
        if (stat_i.expq_done) begin
          state_d = S_ADD;
        end else begin
          cmd_o.op = OP_MUL_Q;
        end
      end
      S_ADD: begin
        cmd_o.op = OP_ADD;
        if (stat_i.limb_last) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat_i.x_last) begin
          cmd_o.op = OP_ACC;
          state_d  = S_SHIFT;
        end else begin
          cmd_o.op = OP_NEXT;
          state_d  = S_TERM;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = S_ROUND;
        end else begin
          cmd_o.op = OP_SHIFT;
        end
      end
      S_ROUND: begin
        cmd_o.op = OP_ROUND;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = OP_PUSH;
          push     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
